// File: hw/rtl/rau_pkg.sv
// Package for the rational arithmetic unit.
// Holds widths, operation, error and select codes and the controller/datapath structs.
// No dependencies.
`default_nettype none
package rau_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FIELD_BITS = 32;

    localparam logic [2:0] FN_ADD = 3'd0;
    localparam logic [2:0] FN_SUB = 3'd1;
    localparam logic [2:0] FN_MUL = 3'd2;
    localparam logic [2:0] FN_DIV = 3'd3;
    localparam logic [2:0] FN_CMP = 3'd4;

    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_ZDEN = 2'd1;
    localparam logic [1:0] ERR_DIV0 = 2'd2;
    localparam logic [1:0] ERR_OVF  = 2'd3;

    localparam logic [1:0] DS_FA = 2'd0;
    localparam logic [1:0] DS_FB = 2'd1;
    localparam logic [1:0] DS_NR = 2'd2;
    localparam logic [1:0] DS_DR = 2'd3;

    localparam logic [1:0] MS_A = 2'd0;
    localparam logic [1:0] MS_B = 2'd1;
    localparam logic [1:0] MS_C = 2'd2;

    typedef struct packed {
        logic       load;
        logic       gcd_go;
        logic       gcd_sel;
        logic       div_go;
        logic [1:0] div_sel;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       comb;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic early;
        logic addsub;
        logic cmp;
        logic gcd_done;
        logic div_done;
    } t_stat;

endpackage
`default_nettype wire

// File: hw/rtl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit.
// Depends on rau_pkg, rau_ctrl and rau_dp.
//
// The slave channel takes one transaction per operation: tuser carries the
// operation code, tdata the two fractions. The master channel returns one
// result transaction with the reduced fraction, the compare flags and, in
// tuser, the error code. One operation is in flight at a time; a new one is
// taken as soon as the previous result sits in the output register.
// Latency is data dependent. Each quotient occupies the shared bit-serial
// divider, and each GCD runs one subtract or shift step per cycle on
// double-width values. Add and subtract use two GCD runs and four divisions;
// multiply and divide use one GCD and two divisions; compare and early errors
// use no GCD run and no division.
// A synchronous reset returns the controller to idle and drops the output
// valid. While the receiver stalls, the result holds and the next operation
// waits in the controller before its own result is written.
`default_nettype none
module rational_arithmetic_unit #(
    parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // a_num, a_den, b_num, b_den
    input  wire logic [127:0] s_axis_tdata,
    // func
    input  wire logic [2:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // res_num, res_den, is_less, is_equal, is_greater, zero padding
    output logic [71:0]       m_axis_tdata,
    // error_code
    output logic [1:0]        m_axis_tuser
);
    localparam int FB = rau_pkg::FIELD_BITS;

    rau_pkg::t_cmd  cmd;
    rau_pkg::t_stat stat;
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic        lt, eq, gt;

    rau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    rau_dp #(.W(WORD_BITS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_func       (s_axis_tuser),
        .i_a_num      (s_axis_tdata[WORD_BITS-1:0]),
        .i_a_den      (s_axis_tdata[FB+WORD_BITS-1:FB]),
        .i_b_num      (s_axis_tdata[2*FB+WORD_BITS-1:2*FB]),
        .i_b_den      (s_axis_tdata[3*FB+WORD_BITS-1:3*FB]),
        .o_res_num    (res_num),
        .o_res_den    (res_den),
        .o_is_less    (lt),
        .o_is_equal   (eq),
        .o_is_greater (gt),
        .o_error_code (m_axis_tuser)
    );

    assign m_axis_tdata = {6'd0, gt, eq, lt, res_den, res_num};
endmodule
`default_nettype wire

// File: hw/rtl/rau_gcd.sv
// Binary GCD unit, one subtract or shift step per cycle.
// Uses no package items.
`default_nettype none
module rau_gcd #(
    parameter int DW = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_a,
    input  wire logic [DW-1:0] i_b,
    output logic               o_done,
    output logic [DW-1:0]      o_gcd
);
    localparam int KW = $clog2(DW);

    logic [DW-1:0] r_x, r_y, r_g;
    logic [KW-1:0] r_k;
    logic          r_busy, r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= i_a;
                r_y    <= i_b;
                r_k    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_x == '0) begin
                    r_g    <= r_y << r_k;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else if (r_y == '0) begin
                    r_g    <= r_x << r_k;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else if (!r_x[0] && !r_y[0]) begin
                    r_x <= r_x >> 1;
                    r_y <= r_y >> 1;
                    r_k <= r_k + 1'b1;
                end else if (!r_x[0]) begin
                    r_x <= r_x >> 1;
                end else if (!r_y[0]) begin
                    r_y <= r_y >> 1;
                end else if (r_x >= r_y) begin
                    r_x <= r_x - r_y;
                end else begin
                    r_y <= r_y - r_x;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_gcd  = r_g;
endmodule
`default_nettype wire

// File: hw/rtl/rau_div.sv
// Restoring divider, one quotient bit per cycle.
// Uses no package items.
`default_nettype none
module rau_div #(
    parameter int DW = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_done,
    output logic [DW-1:0]      o_quot
);
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_rem, r_q, r_d;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [DW:0]   trial;

    assign trial = {r_rem, r_q[DW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= '0;
                r_q    <= i_num;
                r_d    <= i_den;
                r_cnt  <= CW'(DW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (trial >= {1'b0, r_d}) begin
                    r_rem <= DW'(trial - {1'b0, r_d});
                    r_q   <= {r_q[DW-2:0], 1'b1};
                end else begin
                    r_rem <= trial[DW-1:0];
                    r_q   <= {r_q[DW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire

// File: hw/rtl/rau_dp.sv
// Datapath: operand registers, multiplier, GCD and divider units, result registers.
// Depends on rau_pkg, rau_gcd and rau_div.
`default_nettype none
module rau_dp #(
    parameter int W = rau_pkg::WORD_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rau_pkg::t_cmd i_cmd,
    output rau_pkg::t_stat     o_stat,
    input  wire logic [2:0]    i_func,
    input  wire logic [W-1:0]  i_a_num,
    input  wire logic [W-1:0]  i_a_den,
    input  wire logic [W-1:0]  i_b_num,
    input  wire logic [W-1:0]  i_b_den,
    output logic [31:0]        o_res_num,
    output logic [30:0]        o_res_den,
    output logic               o_is_less,
    output logic               o_is_equal,
    output logic               o_is_greater,
    output logic [1:0]         o_error_code
);
    localparam int DW = 2 * W;
    localparam logic [DW-1:0] LIM = DW'(1) << (W - 1);

    logic [2:0]    r_func;
    logic [W-1:0]  r_an, r_ad, r_bn, r_bd, r_fa, r_fb;
    logic [DW-1:0] r_m1, r_m2, r_den, r_nmag, r_nred, r_dred;
    logic          r_neg;

    logic [W-1:0]  an_mag, ad_mag, bn_mag, bd_mag, mx, my;
    logic          sa, sb, n2, addsub, early, neg_f, ovf;
    logic [DW-1:0] prod, gcd_a, gcd_b, gcd_g, div_n, quot;
    logic          gcd_done, div_done;
    logic signed [DW:0]  s1, s2;
    logic signed [W-1:0] num_w;

    logic [31:0] r_res_num;
    logic [30:0] r_res_den;
    logic        r_lt, r_eq, r_gt;
    logic [1:0]  r_err;

    assign an_mag = r_an[W-1] ? W'(-r_an) : r_an;
    assign ad_mag = r_ad[W-1] ? W'(-r_ad) : r_ad;
    assign bn_mag = r_bn[W-1] ? W'(-r_bn) : r_bn;
    assign bd_mag = r_bd[W-1] ? W'(-r_bd) : r_bd;
    assign sa = (r_an[W-1] ^ r_ad[W-1]) & (r_an != '0);
    assign sb = (r_bn[W-1] ^ r_bd[W-1]) & (r_bn != '0);
    assign addsub = (r_func == rau_pkg::FN_ADD) || (r_func == rau_pkg::FN_SUB);
    assign early = (r_func > rau_pkg::FN_CMP) || (r_ad == '0) || (r_bd == '0)
                 || ((r_func == rau_pkg::FN_DIV) && (r_bn == '0));

    always_comb begin
        case (i_cmd.mul_sel)
            rau_pkg::MS_A: begin
                mx = an_mag;
                my = addsub ? r_fa : ((r_func == rau_pkg::FN_MUL) ? bn_mag : bd_mag);
            end
            rau_pkg::MS_B: begin
                mx = bn_mag;
                my = addsub ? r_fb : ad_mag;
            end
            default: begin
                mx = ad_mag;
                my = addsub ? r_fa : ((r_func == rau_pkg::FN_MUL) ? bd_mag : bn_mag);
            end
        endcase
    end

    assign prod = DW'(mx) * DW'(my);

    assign gcd_a = i_cmd.gcd_sel ? r_nmag : DW'(ad_mag);
    assign gcd_b = i_cmd.gcd_sel ? r_den  : DW'(bd_mag);

    always_comb begin
        case (i_cmd.div_sel)
            rau_pkg::DS_FA: div_n = DW'(bd_mag);
            rau_pkg::DS_FB: div_n = DW'(ad_mag);
            rau_pkg::DS_NR: div_n = r_nmag;
            default:        div_n = r_den;
        endcase
    end

    rau_gcd #(.DW(DW)) u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.gcd_go),
        .i_a     (gcd_a),
        .i_b     (gcd_b),
        .o_done  (gcd_done),
        .o_gcd   (gcd_g)
    );

    rau_div #(.DW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_go),
        .i_num   (div_n),
        .i_den   (gcd_g),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    assign n2 = (sb ^ (r_func == rau_pkg::FN_SUB)) & (r_m2 != '0);
    assign s1 = sa ? -$signed({1'b0, r_m1}) : $signed({1'b0, r_m1});
    assign s2 = sb ? -$signed({1'b0, r_m2}) : $signed({1'b0, r_m2});
    assign neg_f = r_neg & (r_nred != '0);
    assign ovf = (r_dred > LIM - 1'b1) || (r_nred > (neg_f ? LIM : LIM - 1'b1));
    assign num_w = neg_f ? W'(-r_nred) : W'(r_nred);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_an   <= i_a_num;
            r_ad   <= i_a_den;
            r_bn   <= i_b_num;
            r_bd   <= i_b_den;
        end
        if (div_done) begin
            case (i_cmd.div_sel)
                rau_pkg::DS_FA: r_fa   <= quot[W-1:0];
                rau_pkg::DS_FB: r_fb   <= quot[W-1:0];
                rau_pkg::DS_NR: r_nred <= quot;
                default:        r_dred <= quot;
            endcase
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                rau_pkg::MS_A: r_m1  <= prod;
                rau_pkg::MS_B: r_m2  <= prod;
                default:       r_den <= prod;
            endcase
        end
        if (i_cmd.comb) begin
            if (!addsub) begin
                r_nmag <= r_m1;
                r_neg  <= sa ^ sb;
            end else if (sa == n2) begin
                r_nmag <= r_m1 + r_m2;
                r_neg  <= sa;
            end else if (r_m1 >= r_m2) begin
                r_nmag <= r_m1 - r_m2;
                r_neg  <= sa;
            end else begin
                r_nmag <= r_m2 - r_m1;
                r_neg  <= n2;
            end
        end
        if (i_cmd.out_load) begin
            r_res_num <= '0;
            r_res_den <= '0;
            r_lt      <= 1'b0;
            r_eq      <= 1'b0;
            r_gt      <= 1'b0;
            r_err     <= rau_pkg::ERR_OK;
            if (r_func > rau_pkg::FN_CMP) begin
                r_err <= rau_pkg::ERR_OK;
            end else if ((r_ad == '0) || (r_bd == '0)) begin
                r_err <= rau_pkg::ERR_ZDEN;
            end else if ((r_func == rau_pkg::FN_DIV) && (r_bn == '0)) begin
                r_err <= rau_pkg::ERR_DIV0;
            end else if (r_func == rau_pkg::FN_CMP) begin
                r_lt <= s1 < s2;
                r_eq <= s1 == s2;
                r_gt <= s1 > s2;
            end else if (ovf) begin
                r_err <= rau_pkg::ERR_OVF;
            end else begin
                r_res_num <= 32'(num_w);
                r_res_den <= 31'(r_dred);
            end
        end
    end

    assign o_stat = '{early: early, addsub: addsub,
                      cmp: (r_func == rau_pkg::FN_CMP),
                      gcd_done: gcd_done, div_done: div_done};

    assign o_res_num    = r_res_num;
    assign o_res_den    = r_res_den;
    assign o_is_less    = r_lt;
    assign o_is_equal   = r_eq;
    assign o_is_greater = r_gt;
    assign o_error_code = r_err;
endmodule
`default_nettype wire

// File: hw/rtl/rau_ctrl.sv
// Controller state machine that sequences the datapath for one transaction.
// Depends on rau_pkg.
`default_nettype none
module rau_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire rau_pkg::t_stat i_stat,
    output rau_pkg::t_cmd       o_cmd
);
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CHECK = 5'd1;
    localparam logic [4:0] S_G1    = 5'd2;
    localparam logic [4:0] S_G1W   = 5'd3;
    localparam logic [4:0] S_DA    = 5'd4;
    localparam logic [4:0] S_DAW   = 5'd5;
    localparam logic [4:0] S_DB    = 5'd6;
    localparam logic [4:0] S_DBW   = 5'd7;
    localparam logic [4:0] S_MA    = 5'd8;
    localparam logic [4:0] S_MB    = 5'd9;
    localparam logic [4:0] S_MC    = 5'd10;
    localparam logic [4:0] S_COMB  = 5'd11;
    localparam logic [4:0] S_G2    = 5'd12;
    localparam logic [4:0] S_G2W   = 5'd13;
    localparam logic [4:0] S_DC    = 5'd14;
    localparam logic [4:0] S_DCW   = 5'd15;
    localparam logic [4:0] S_DD    = 5'd16;
    localparam logic [4:0] S_DDW   = 5'd17;
    localparam logic [4:0] S_OUT   = 5'd18;

    logic [4:0] r_state, n_state;
    logic       r_ov, n_ov;
    rau_pkg::t_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd = '0;
        cmd.mul_sel = rau_pkg::MS_A;
        cmd.div_sel = rau_pkg::DS_FA;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.early) begin
                    n_state = S_OUT;
                end else if (i_stat.addsub) begin
                    n_state = S_G1;
                end else begin
                    n_state = S_MA;
                end
            end
            S_G1: begin
                cmd.gcd_go = 1'b1;
                n_state = S_G1W;
            end
            S_G1W: if (i_stat.gcd_done) n_state = S_DA;
            S_DA: begin
                cmd.div_go = 1'b1;
                n_state = S_DAW;
            end
            S_DAW: if (i_stat.div_done) n_state = S_DB;
            S_DB: begin
                cmd.div_go = 1'b1;
                cmd.div_sel = rau_pkg::DS_FB;
                n_state = S_DBW;
            end
            S_DBW: begin
                cmd.div_sel = rau_pkg::DS_FB;
                if (i_stat.div_done) n_state = S_MA;
            end
            S_MA: begin
                cmd.mul_en = 1'b1;
                n_state = S_MB;
            end
            S_MB: begin
                cmd.mul_en = 1'b1;
                cmd.mul_sel = rau_pkg::MS_B;
                n_state = S_MC;
            end
            S_MC: begin
                cmd.mul_en = 1'b1;
                cmd.mul_sel = rau_pkg::MS_C;
                n_state = S_COMB;
            end
            S_COMB: begin
                cmd.comb = 1'b1;
                n_state = i_stat.cmp ? S_OUT : S_G2;
            end
            S_G2: begin
                cmd.gcd_go = 1'b1;
                cmd.gcd_sel = 1'b1;
                n_state = S_G2W;
            end
            S_G2W: begin
                cmd.gcd_sel = 1'b1;
                if (i_stat.gcd_done) n_state = S_DC;
            end
            S_DC: begin
                cmd.div_go = 1'b1;
                cmd.div_sel = rau_pkg::DS_NR;
                n_state = S_DCW;
            end
            S_DCW: begin
                cmd.div_sel = rau_pkg::DS_NR;
                if (i_stat.div_done) n_state = S_DD;
            end
            S_DD: begin
                cmd.div_go = 1'b1;
                cmd.div_sel = rau_pkg::DS_DR;
                n_state = S_DDW;
            end
            S_DDW: begin
                cmd.div_sel = rau_pkg::DS_DR;
                if (i_stat.div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ov || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_ov = r_ov;
        if (cmd.out_load) begin
            n_ov = 1'b1;
        end else if (i_out_ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
endmodule
`default_nettype wire

// File: tb/rau_checker.sv
// Checker for the rational arithmetic unit: watches both stream channels,
// predicts each result from the accepted operation and compares field by field.
// Depends on rau_pkg.
module rau_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [127:0] s_tdata,
    input  wire logic [2:0]   s_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [71:0]  m_tdata,
    input  wire logic [1:0]   m_tuser,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] num;
        logic [30:0] den;
        logic        lt;
        logic        eq;
        logic        gt;
        logic [1:0]  err;
    } t_fraction_result;

    t_fraction_result expected_results[$];

    function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return (x == 0) ? 64'd1 : x;
    endfunction

    function automatic logic [63:0] magnitude(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic t_fraction_result reduce_fraction(logic neg, logic [63:0] nmag,
                                                         logic [63:0] dmag);
        t_fraction_result r;
        logic [63:0] g;
        longint sn;
        r = '0;
        g = euclid_gcd(nmag, dmag);
        nmag = nmag / g;
        dmag = dmag / g;
        if (nmag == 0) begin
            neg = 1'b0;
            dmag = 64'd1;
        end
        if (dmag > 64'h7FFF_FFFF || nmag > (neg ? 64'h8000_0000 : 64'h7FFF_FFFF)) begin
            r.err = rau_pkg::ERR_OVF;
            return r;
        end
        sn = neg ? -longint'(nmag) : longint'(nmag);
        r.num = sn[31:0];
        r.den = dmag[30:0];
        r.err = rau_pkg::ERR_OK;
        return r;
    endfunction

    function automatic t_fraction_result predict_fraction(logic [2:0] op, logic [127:0] d);
        t_fraction_result r;
        longint an, ad, bn, bd, pa, pb;
        logic [63:0] adm, bdm, g, fa, fb, m1, m2, nmag;
        logic n1, n2, neg;
        r = '0;
        an = longint'(signed'(d[31:0]));
        ad = longint'(signed'(d[63:32]));
        bn = longint'(signed'(d[95:64]));
        bd = longint'(signed'(d[127:96]));
        if (op > rau_pkg::FN_CMP) return r;
        if (ad == 0 || bd == 0) begin
            r.err = rau_pkg::ERR_ZDEN;
            return r;
        end
        if (ad < 0) an = -an;
        if (bd < 0) bn = -bn;
        adm = magnitude(ad);
        bdm = magnitude(bd);
        case (op)
            rau_pkg::FN_ADD, rau_pkg::FN_SUB: begin
                g = euclid_gcd(adm, bdm);
                fa = bdm / g;
                fb = adm / g;
                m1 = magnitude(an) * fa;
                n1 = an < 0;
                m2 = magnitude(bn) * fb;
                n2 = (bn < 0) != (op == rau_pkg::FN_SUB);
                if (m2 == 0) n2 = 1'b0;
                if (n1 == n2) begin
                    nmag = m1 + m2;
                    neg = n1;
                end else if (m1 >= m2) begin
                    nmag = m1 - m2;
                    neg = n1;
                end else begin
                    nmag = m2 - m1;
                    neg = n2;
                end
                r = reduce_fraction(neg, nmag, adm * fa);
            end
            rau_pkg::FN_MUL: r = reduce_fraction((an < 0) != (bn < 0),
                                                 magnitude(an) * magnitude(bn), adm * bdm);
            rau_pkg::FN_DIV: begin
                if (bn == 0) r.err = rau_pkg::ERR_DIV0;
                else r = reduce_fraction((an < 0) != (bn < 0), magnitude(an) * bdm,
                                         adm * magnitude(bn));
            end
            default: begin
                pa = an * longint'(bdm);
                pb = bn * longint'(adm);
                r.lt = pa < pb;
                r.eq = pa == pb;
                r.gt = pa > pb;
            end
        endcase
        return r;
    endfunction

    assign o_pending = expected_results.size();

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_fraction_result got, want;
        if (i_rst_n && s_tvalid && s_tready)
            expected_results.push_back(predict_fraction(s_tuser, s_tdata));
        if (i_rst_n && m_tvalid && m_tready) begin
            got.num = m_tdata[31:0];
            got.den = m_tdata[62:32];
            got.lt  = m_tdata[63];
            got.eq  = m_tdata[64];
            got.gt  = m_tdata[65];
            got.err = m_tuser;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $realtime, got);
                o_fail_count <= o_fail_count + 1;
            end else begin
                want = expected_results.pop_front();
                if (got != want) begin
                    $display("%0t: mismatch expected num=%h den=%h lt=%b eq=%b gt=%b err=%0d",
                             $realtime, want.num, want.den, want.lt, want.eq, want.gt,
                             want.err);
                    $display("%0t:          actual   num=%h den=%h lt=%b eq=%b gt=%b err=%0d",
                             $realtime, got.num, got.den, got.lt, got.eq, got.gt, got.err);
                    o_fail_count <= o_fail_count + 1;
                end
            end
        end
    end
endmodule

// File: tb/tb.sv
// Top of the rational arithmetic unit testbench: clock, reset, stimulus and verdict.
// Depends on rau_pkg, rational_arithmetic_unit and rau_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic [2:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [71:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    int           fail_count;
    int           pending;
    bit           hold_off = 1'b0;

    rational_arithmetic_unit DUT (.*);

    rau_checker u_checker (
        .i_clk, .i_rst_n,
        .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
        .s_tdata(s_axis_tdata), .s_tuser(s_axis_tuser),
        .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
        .m_tdata(m_axis_tdata), .m_tuser(m_axis_tuser),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($urandom_range(0, 2)) - 32'd1;
            3, 4: return 32'($urandom_range(0, 40)) - 32'd20;
            5, 6: return 32'($urandom_range(0, 2000)) - 32'd1000;
            7: return 32'($urandom_range(0, 200000)) - 32'd100000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] random_den();
        logic [31:0] d;
        d = random_word();
        if (d == 0 && $urandom_range(0, 3) != 0) d = 32'd1;
        return d;
    endfunction

    task automatic send_operation(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                                  logic [31:0] bn, logic [31:0] bd);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {bd, bn, ad, an};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic idle_gap();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 300) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_off)
            m_axis_tready <= 1'b0;
        else
            case ($urandom_range(0, 7))
                0: m_axis_tready <= 1'b0;
                1: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= 1'b1;
            endcase
    end

    initial begin
        #60_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int burst;
        int wait_cycles;
        logic [2:0] op;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed: field extremes, each operation and each error path.
        send_operation(rau_pkg::FN_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        send_operation(rau_pkg::FN_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
        send_operation(rau_pkg::FN_MUL, -32'sd3, 32'd4, 32'd8, -32'sd9);
        send_operation(rau_pkg::FN_DIV, 32'd2, 32'd3, -32'sd4, 32'd5);
        send_operation(rau_pkg::FN_CMP, 32'd1, 32'd3, 32'd1, 32'd2);
        send_operation(rau_pkg::FN_CMP, 32'd2, 32'd4, 32'd1, 32'd2);
        send_operation(rau_pkg::FN_CMP, -32'sd1, -32'sd3, 32'd1, 32'd4);
        send_operation(rau_pkg::FN_ADD, 32'd1, 32'd0, 32'd1, 32'd2);
        send_operation(rau_pkg::FN_CMP, 32'd1, 32'd2, 32'd1, 32'd0);
        send_operation(rau_pkg::FN_DIV, 32'd1, 32'd2, 32'd0, 32'd7);
        send_operation(rau_pkg::FN_MUL, 32'h7FFF_FFFF, 32'd1, 32'd2, 32'd1);
        send_operation(rau_pkg::FN_ADD, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
        send_operation(rau_pkg::FN_DIV, 32'd1, 32'h8000_0000, 32'd1, 32'd1);
        send_operation(rau_pkg::FN_MUL, 32'h8000_0000, 32'hFFFF_FFFF, 32'd1, 32'd1);
        send_operation(rau_pkg::FN_MUL, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
        send_operation(rau_pkg::FN_SUB, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                       32'h7FFF_FFFF);
        send_operation(rau_pkg::FN_MUL, 32'd0, -32'sd5, 32'd3, 32'd7);
        send_operation(rau_pkg::FN_CMP, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h8000_0000);
        send_operation(3'd5, 32'd1, 32'd0, 32'd1, 32'd1);
        send_operation(3'd6, 32'd1, 32'd1, 32'd1, 32'd1);
        send_operation(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Long receiver hold-off while operations keep coming.
        hold_off = 1'b1;
        fork
            begin
                wait_cycles = 0;
                while (wait_cycles < 3000) begin
                    @(posedge i_clk);
                    wait_cycles++;
                end
                hold_off = 1'b0;
            end
            repeat (4) send_operation(rau_pkg::FN_CMP, random_word(), 32'd3,
                                      random_word(), 32'd5);
        join
        for (int i = 0; i < 1700; ) begin
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst && i < 1700; k++, i++) begin
                op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                  : 3'($urandom_range(0, 4));
                send_operation(op, random_word(), random_den(), random_word(), random_den());
            end
            idle_gap();
        end
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
